/* hw/rtl/key_value_table_engine_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the key/value table engine
// Wrappers for concurrent assertions; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_ENGINE_MACROS_SVH
`define KEY_VALUE_TABLE_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define KVT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("kvt assertion failed");
`define KVT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("kvt assertion failed");
`else
`define KVT_ASSERT(lbl, clk, rstn, prop)
`define KVT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Types, codes and defaults shared by the key/value table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kvt_pkg;
	localparam int CAPACITY_DEF   = 64;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_REG_BITS   = 7;
	localparam logic [MAX_REG_BITS-1:0] ENTRY_LIMIT_RST = 7'd64;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_INVALID  = 3'd1;
	localparam status_t ST_NOTFOUND = 3'd2;
	localparam status_t ST_EXISTS   = 3'd3;
	localparam status_t ST_FULL     = 3'd4;
	localparam status_t ST_NOPERM   = 3'd5;

	localparam logic [2:0] CMD_LOOKUP = 3'd0;
	localparam logic [2:0] CMD_UPDATE = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_LKDEL  = 3'd3;
	localparam logic [2:0] CMD_NEXT   = 3'd4;

	localparam logic [2:0] MODE_ANY     = 3'd0;
	localparam logic [2:0] MODE_NOEXIST = 3'd1;
	localparam logic [2:0] MODE_EXIST   = 3'd2;

	localparam logic [1:0] CFG_ENTRY_LIMIT = 2'd0;
	localparam logic [1:0] CFG_READ_ONLY   = 2'd1;
	localparam logic [1:0] CFG_WRITE_ONLY  = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic start;
		logic sample;
	} scan_ctrl_t;
endpackage
`default_nettype wire

/* hw/rtl/kvt_cmd_if.sv */
// ----------------------------------------------------------------------------
// kvt_cmd_if / kvt_rsp_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface kvt_cmd_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            cmd;
	logic [KEY_BITS-1:0]   key;
	logic                  has_key;
	logic [VALUE_BITS-1:0] value;
	logic [2:0]            update_mode;
	modport source (output valid, cmd, key, has_key, value, update_mode, input ready);
	modport sink (input valid, cmd, key, has_key, value, update_mode, output ready);
endinterface

interface kvt_rsp_if;
	import kvt_pkg::*;
	logic        valid;
	logic        ready;
	status_t     status;
	logic [31:0] hit_value;
	logic [31:0] succ_key;
	modport source (output valid, status, hit_value, succ_key, input ready);
	modport sink (input valid, status, hit_value, succ_key, output ready);
endinterface
`default_nettype wire

/* hw/rtl/kvt_ram.sv */
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/kvt_scan.sv */
// ----------------------------------------------------------------------------
// kvt_scan
// Collects match, free slot, first entry and following entry over a scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kvt_scan #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kvt_pkg::scan_ctrl_t         ctrl,
	input  wire logic [$clog2(CAPACITY)-1:0] addr,
	input  wire logic                        rd_valid,
	input  wire logic [KEY_BITS-1:0]         rd_key,
	input  wire logic [VALUE_BITS-1:0]       rd_value,
	input  wire logic [KEY_BITS-1:0]         key,
	output logic                             found,
	output logic [$clog2(CAPACITY)-1:0]      match_idx,
	output logic [VALUE_BITS-1:0]            match_val,
	output logic                             nxt_found,
	output logic [KEY_BITS-1:0]              nxt_key,
	output logic                             first_found,
	output logic [KEY_BITS-1:0]              first_key,
	output logic                             free_found,
	output logic [$clog2(CAPACITY)-1:0]      free_idx
);
	import kvt_pkg::*;

	logic hit;

	assign hit = rd_valid && (rd_key == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found       <= 1'b0;
			nxt_found   <= 1'b0;
			first_found <= 1'b0;
			free_found  <= 1'b0;
		end else if (ctrl.start) begin
			found       <= 1'b0;
			nxt_found   <= 1'b0;
			first_found <= 1'b0;
			free_found  <= 1'b0;
		end else if (ctrl.sample) begin
			if (hit && !found) begin
				found <= 1'b1;
			end else if (rd_valid && found && !nxt_found) begin
				nxt_found <= 1'b1;
			end
			if (rd_valid) begin
				first_found <= 1'b1;
			end
			if (!rd_valid) begin
				free_found <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sample) begin
			if (hit && !found) begin
				match_idx <= addr;
				match_val <= rd_value;
			end else if (rd_valid && found && !nxt_found) begin
				nxt_key <= rd_key;
			end
			if (rd_valid && !first_found) begin
				first_key <= rd_key;
			end
			if (!rd_valid && !free_found) begin
				free_idx <= addr;
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/key_value_table_engine.sv */
// ----------------------------------------------------------------------------
// key_value_table_engine
// Fixed-capacity key/value table with lookup, update, delete and iteration.
// ----------------------------------------------------------------------------
// Commands arrive on the req channel and each gives exactly one result on
// the rsp channel; a transfer happens when valid and ready are both high.
// The user writes the entry limit, read-only and write-only registers through
// the cfg port only while the engine is idle; the block does not enforce it.
// The table lives in one RAM holding a valid bit, key and value per slot.
// Each command scans every slot through the single read port, one slot per
// cycle, then decides and writes back at most one slot.
// After the command transfer the engine scans every slot, passes through
// S_DRAIN and loads the result in S_DECIDE; a new command is taken in the
// cycle after the result is loaded, so one command is in flight at a time.
// After reset the engine clears every RAM slot, with req.ready
// low; configuration writes are taken during that time.
// The result sits in an output register; if rsp is stalled, the engine
// holds the finished command until the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "key_value_table_engine_macros.svh"
module key_value_table_engine #(
	parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [kvt_pkg::MAX_REG_BITS-1:0] cfg_wdata,
	kvt_cmd_if.sink                              req,
	kvt_rsp_if.source                            rsp
);
	import kvt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > MAX_REG_BITS) ? CW : MAX_REG_BITS;
	localparam int WW = 1 + KEY_BITS + VALUE_BITS;

	state_t                  state_q, state_d;
	logic [AW-1:0]           addr_q, addr_d;
	logic                    rd_pend_s1;
	logic [AW-1:0]           rd_addr_s1;
	logic [CW-1:0]           count_q;
	logic [MAX_REG_BITS-1:0] max_q;
	logic                    ro_q, wo_q;
	logic [2:0]              cmd_q;
	logic [KEY_BITS-1:0]     key_q;
	logic                    has_key_q;
	logic [VALUE_BITS-1:0]   value_q;
	logic [2:0]              mode_q;
	logic                    rsp_valid_q;
	status_t                 status_q;
	logic [31:0]             vout_q, nkey_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [WW-1:0]           ram_wdata, ram_rdata;
	logic                    issue, load_out, last;
	scan_ctrl_t              sctrl;

	logic                    found, nxt_found, first_found, free_found;
	logic [AW-1:0]           match_idx, free_idx;
	logic [VALUE_BITS-1:0]   match_val;
	logic [KEY_BITS-1:0]     nxt_key, first_key;

	status_t                 dec_status;
	logic [31:0]             dec_vout, dec_nkey;
	logic                    dec_we, dec_valid, dec_inc, dec_dec;
	logic [AW-1:0]           dec_addr;
	logic [LW-1:0]           limit;

	kvt_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign sctrl.start  = req.valid && req.ready;
	assign sctrl.sample = rd_pend_s1;

	kvt_scan #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (sctrl),
		.addr        (rd_addr_s1),
		.rd_valid    (ram_rdata[WW-1]),
		.rd_key      (ram_rdata[VALUE_BITS +: KEY_BITS]),
		.rd_value    (ram_rdata[VALUE_BITS-1:0]),
		.key         (key_q),
		.found       (found),
		.match_idx   (match_idx),
		.match_val   (match_val),
		.nxt_found   (nxt_found),
		.nxt_key     (nxt_key),
		.first_found (first_found),
		.first_key   (first_key),
		.free_found  (free_found),
		.free_idx    (free_idx)
	);

	assign last  = (addr_q == AW'(CAPACITY - 1));
	assign limit = (LW'(max_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_q);

	always_comb begin
		dec_status = ST_OK;
		dec_vout   = '0;
		dec_nkey   = '0;
		dec_we     = 1'b0;
		dec_valid  = 1'b1;
		dec_inc    = 1'b0;
		dec_dec    = 1'b0;
		dec_addr   = match_idx;
		unique case (cmd_q)
			CMD_LOOKUP: begin
				if (wo_q) begin
					dec_status = ST_NOPERM;
				end else if (!found) begin
					dec_status = ST_NOTFOUND;
				end else begin
					dec_vout = 32'(match_val);
				end
			end
			CMD_UPDATE: begin
				if (mode_q != MODE_ANY && mode_q != MODE_NOEXIST && mode_q != MODE_EXIST) begin
					dec_status = ST_INVALID;
				end else if (mode_q == MODE_NOEXIST && found) begin
					dec_status = ST_EXISTS;
				end else if (mode_q == MODE_EXIST && !found) begin
					dec_status = ST_NOTFOUND;
				end else if (found) begin
					dec_we = 1'b1;
				end else if (LW'(count_q) >= limit) begin
					dec_status = ST_FULL;
				end else if (ro_q) begin
					dec_status = ST_NOPERM;
				end else if (!free_found) begin
					dec_status = ST_FULL;
				end else begin
					dec_we   = 1'b1;
					dec_addr = free_idx;
					dec_inc  = 1'b1;
				end
			end
			CMD_DELETE, CMD_LKDEL: begin
				if (!found) begin
					dec_status = ST_NOTFOUND;
				end else begin
					dec_we    = 1'b1;
					dec_valid = 1'b0;
					dec_dec   = 1'b1;
					if (cmd_q == CMD_LKDEL) begin
						dec_vout = 32'(match_val);
					end
				end
			end
			CMD_NEXT: begin
				if (wo_q) begin
					dec_status = ST_NOPERM;
				end else if (has_key_q && found) begin
					if (nxt_found) begin
						dec_nkey = 32'(nxt_key);
					end else begin
						dec_status = ST_NOTFOUND;
					end
				end else if (first_found) begin
					dec_nkey = 32'(first_key);
				end else begin
					dec_status = ST_NOTFOUND;
				end
			end
			default: begin
				dec_status = ST_INVALID;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		issue     = 1'b0;
		load_out  = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				addr_d = last ? '0 : addr_q + AW'(1);
				if (last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				addr_d    = '0;
				if (req.valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				issue  = 1'b1;
				addr_d = last ? '0 : addr_q + AW'(1);
				if (last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out  = 1'b1;
					ram_we    = dec_we;
					ram_waddr = dec_addr;
					ram_wdata = {dec_valid, key_q, value_q};
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			rd_pend_s1  <= 1'b0;
			count_q     <= '0;
			max_q       <= ENTRY_LIMIT_RST;
			ro_q        <= 1'b0;
			wo_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			addr_q     <= addr_d;
			rd_pend_s1 <= issue;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
				if (dec_inc) begin
					count_q <= count_q + CW'(1);
				end else if (dec_dec && count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENTRY_LIMIT: max_q <= cfg_wdata;
					CFG_READ_ONLY:   ro_q  <= cfg_wdata[0];
					CFG_WRITE_ONLY:  wo_q  <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q;
		if (req.valid && req.ready) begin
			cmd_q     <= req.cmd;
			key_q     <= req.key;
			has_key_q <= req.has_key;
			value_q   <= req.value;
			mode_q    <= req.update_mode;
		end
		if (load_out) begin
			status_q <= dec_status;
			vout_q   <= dec_vout;
			nkey_q   <= dec_nkey;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.hit_value = vout_q;
	assign rsp.succ_key  = nkey_q;

	`KVT_ASSERT(a_count_bound, clk, arst_n, LW'(count_q) <= LW'(CAPACITY))
	`KVT_ASSERT(a_no_write_in_scan, clk, arst_n, (state_q == S_SCAN) |-> !ram_we)
	`KVT_ASSERT(a_accept_starts_scan, clk, arst_n, (req.valid && req.ready) |=> (state_q == S_SCAN))
	`KVT_ASSERT(a_result_after_decide, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == S_DECIDE))
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Key/value table engine testbench
// Directed and random command streams against a behavioral table that
// predicts status, value and next key for every command transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import kvt_pkg::*;

	localparam int SLOTS = 64;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 5000;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [2:0] CMD_BAD_LO = 3'd5;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;
	localparam logic [2:0] MODE_BAD_LO = 3'd3;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;

	typedef struct packed {
		status_t     status;
		logic [31:0] hit_value;
		logic [31:0] succ_key;
	} kv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [MAX_REG_BITS-1:0] cfg_wdata = '0;

	kvt_cmd_if #(.KEY_BITS(32), .VALUE_BITS(32)) req_if();
	kvt_rsp_if rsp_if();

	key_value_table_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #5 clk = ~clk;

	bit          tbl_used[SLOTS];
	logic [31:0] tbl_key[SLOTS];
	logic [31:0] tbl_val[SLOTS];
	int          tbl_count;
	int          lim_entries;
	bit          lock_inserts;
	bit          lock_queries;

	kv_result_t expected_results[$];
	logic [31:0] key_pool[80];
	int idle_pct = 15;
	int upd_pct = 40;
	int errors = 0;
	int quiet_cycles = 0;

	initial begin
		req_if.valid = 1'b0;
		req_if.cmd = '0;
		req_if.key = '0;
		req_if.has_key = 1'b0;
		req_if.value = '0;
		req_if.update_mode = '0;
		rsp_if.ready = 1'b0;
	end

	function automatic int find_key(logic [31:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_used[i] && tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic kv_result_t predict_table(logic [2:0] cmd, logic [31:0] k, logic hk,
			logic [31:0] v, logic [2:0] mode);
		kv_result_t r;
		int s;
		int n;
		int limit;
		r = '{ST_OK, 32'd0, 32'd0};
		limit = (lim_entries > SLOTS) ? SLOTS : lim_entries;
		case (cmd)
			CMD_LOOKUP: begin
				if (lock_queries) begin
					r.status = ST_NOPERM;
				end else begin
					s = find_key(k);
					if (s < 0) r.status = ST_NOTFOUND;
					else r.hit_value = tbl_val[s];
				end
			end
			CMD_UPDATE: begin
				s = find_key(k);
				if (mode != MODE_ANY && mode != MODE_NOEXIST && mode != MODE_EXIST)
					r.status = ST_INVALID;
				else if (mode == MODE_NOEXIST && s >= 0)
					r.status = ST_EXISTS;
				else if (mode == MODE_EXIST && s < 0)
					r.status = ST_NOTFOUND;
				else if (s >= 0)
					tbl_val[s] = v;
				else if (tbl_count >= limit)
					r.status = ST_FULL;
				else if (lock_inserts)
					r.status = ST_NOPERM;
				else begin
					n = 0;
					while (n < SLOTS && tbl_used[n]) n++;
					if (n >= SLOTS) begin
						r.status = ST_FULL;
					end else begin
						tbl_used[n] = 1'b1;
						tbl_key[n] = k;
						tbl_val[n] = v;
						tbl_count++;
					end
				end
			end
			CMD_DELETE, CMD_LKDEL: begin
				s = find_key(k);
				if (s < 0) begin
					r.status = ST_NOTFOUND;
				end else begin
					if (cmd == CMD_LKDEL) r.hit_value = tbl_val[s];
					tbl_used[s] = 1'b0;
					if (tbl_count > 0) tbl_count--;
				end
			end
			CMD_NEXT: begin
				if (lock_queries) begin
					r.status = ST_NOPERM;
				end else begin
					s = hk ? find_key(k) : -1;
					n = (s < 0) ? 0 : s + 1;
					while (n < SLOTS && !tbl_used[n]) n++;
					if (n >= SLOTS) r.status = ST_NOTFOUND;
					else r.succ_key = tbl_key[n];
				end
			end
			default: r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) rsp_if.ready <= 1'b0;
		else rsp_if.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		kv_result_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (rsp_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_if.status);
					errors++;
				end
				if (rsp_if.hit_value !== want.hit_value) begin
					$error("hit_value: expected %h, got %h", want.hit_value, rsp_if.hit_value);
					errors++;
				end
				if (rsp_if.succ_key !== want.succ_key) begin
					$error("succ_key: expected %h, got %h", want.succ_key, rsp_if.succ_key);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL key_value_table_engine");
			$finish;
		end
	end

	task automatic send_cmd(logic [2:0] cmd, logic [31:0] k, logic hk, logic [31:0] v,
			logic [2:0] mode);
		if ($urandom_range(99) < idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd <= cmd;
		req_if.key <= k;
		req_if.has_key <= hk;
		req_if.value <= v;
		req_if.update_mode <= mode;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		expected_results.push_back(predict_table(cmd, k, hk, v, mode));
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [MAX_REG_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ENTRY_LIMIT: lim_entries = data;
			CFG_READ_ONLY: lock_inserts = data[0];
			CFG_WRITE_ONLY: lock_queries = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_cmd(CMD_LOOKUP, 32'h0, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_NEXT, 32'h0, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_UPDATE, 32'h0, 1'b0, 32'hFFFF_FFFF, MODE_ANY);
		send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 1'b1, 32'h0, MODE_NOEXIST);
		send_cmd(CMD_UPDATE, 32'h1234_5678, 1'b0, 32'hA5A5_5A5A, MODE_ANY);
		send_cmd(CMD_UPDATE, 32'h0, 1'b0, 32'h1, MODE_NOEXIST);
		send_cmd(CMD_UPDATE, 32'hDEAD_BEEF, 1'b0, 32'h1, MODE_EXIST);
		send_cmd(CMD_UPDATE, 32'h0, 1'b0, 32'h5555_AAAA, MODE_EXIST);
		send_cmd(CMD_UPDATE, 32'h7, 1'b0, 32'h7, MODE_BAD_LO);
		send_cmd(CMD_UPDATE, 32'h7, 1'b0, 32'h7, MODE_BAD_HI);
		send_cmd(CMD_LOOKUP, 32'h0, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_NEXT, 32'h0, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_NEXT, 32'hCAFE_0000, 1'b1, 32'h0, MODE_ANY);
		send_cmd(CMD_NEXT, 32'h0, 1'b1, 32'h0, MODE_ANY);
		send_cmd(CMD_NEXT, 32'hFFFF_FFFF, 1'b1, 32'h0, MODE_ANY);
		send_cmd(CMD_NEXT, 32'h1234_5678, 1'b1, 32'h0, MODE_ANY);
		send_cmd(CMD_LKDEL, 32'hFFFF_FFFF, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_LKDEL, 32'hFFFF_FFFF, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_DELETE, 32'h0, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_DELETE, 32'h0, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_BAD_LO, 32'h1234_5678, 1'b1, 32'h0, MODE_ANY);
		send_cmd(CMD_BAD_HI, 32'h1234_5678, 1'b1, 32'h0, MODE_ANY);
		wait_idle();
	endtask

	task automatic test_permissions();
		set_reg(CFG_ENTRY_LIMIT, 7'd2);
		send_cmd(CMD_UPDATE, 32'h11, 1'b0, 32'h11, MODE_ANY);
		send_cmd(CMD_UPDATE, 32'h22, 1'b0, 32'h22, MODE_ANY);
		send_cmd(CMD_UPDATE, 32'h11, 1'b0, 32'h99, MODE_ANY);
		wait_idle();
		set_reg(CFG_ENTRY_LIMIT, 7'd0);
		send_cmd(CMD_UPDATE, 32'h33, 1'b0, 32'h33, MODE_ANY);
		wait_idle();
		set_reg(CFG_ENTRY_LIMIT, 7'd127);
		set_reg(CFG_READ_ONLY, 7'd1);
		set_reg(CFG_UNUSED, 7'h7F);
		send_cmd(CMD_UPDATE, 32'h44, 1'b0, 32'h44, MODE_ANY);
		send_cmd(CMD_UPDATE, 32'h22, 1'b0, 32'h77, MODE_EXIST);
		send_cmd(CMD_LKDEL, 32'h22, 1'b0, 32'h0, MODE_ANY);
		wait_idle();
		set_reg(CFG_READ_ONLY, 7'd0);
		set_reg(CFG_WRITE_ONLY, 7'd1);
		send_cmd(CMD_LOOKUP, 32'h11, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_NEXT, 32'h0, 1'b0, 32'h0, MODE_ANY);
		send_cmd(CMD_UPDATE, 32'h55, 1'b0, 32'h55, MODE_ANY);
		send_cmd(CMD_DELETE, 32'h11, 1'b0, 32'h0, MODE_ANY);
		wait_idle();
		set_reg(CFG_WRITE_ONLY, 7'd0);
	endtask

	task automatic send_random(int count, bit pause_midway);
		int r;
		logic [2:0] cmd;
		logic [2:0] mode;
		logic [31:0] k;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) wait_idle();
			r = $urandom_range(99);
			if (r < upd_pct) cmd = CMD_UPDATE;
			else if (r < upd_pct + (100 - upd_pct) / 4) cmd = CMD_LOOKUP;
			else if (r < upd_pct + (100 - upd_pct) / 2) cmd = CMD_DELETE;
			else if (r < upd_pct + 2 * (100 - upd_pct) / 3) cmd = CMD_LKDEL;
			else if (r < 97) cmd = CMD_NEXT;
			else cmd = 3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
			if ($urandom_range(9) == 0) mode = 3'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
			else mode = 3'($urandom_range(MODE_EXIST, MODE_ANY));
			k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(79)] : 32'($urandom);
			send_cmd(cmd, k, 1'($urandom), 32'($urandom), mode);
		end
		wait_idle();
	endtask

	task automatic test_random();
		int lims[6] = '{127, 64, 5, 0, 40, 64};
		int ups[6] = '{60, 80, 45, 40, 40, 40};
		for (int p = 0; p < 6; p++) begin
			set_reg(CFG_ENTRY_LIMIT, 7'(lims[p]));
			set_reg(CFG_READ_ONLY, 7'(p == 4));
			set_reg(CFG_WRITE_ONLY, 7'(p == 5));
			upd_pct = ups[p];
			idle_pct = (p == 1) ? 0 : 15;
			send_random(200, p == 0);
		end
		idle_pct = 15;
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end
		tbl_count = 0;
		lim_entries = ENTRY_LIMIT_RST;
		lock_inserts = 1'b0;
		lock_queries = 1'b0;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 80; i++) key_pool[i] = 32'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_permissions();
		test_random();
		wait_idle();
		if (errors == 0) $display("PASS key_value_table_engine");
		else $display("FAIL key_value_table_engine");
		$finish;
	end
endmodule
`default_nettype wire
